// File: hdl/mbfs_pkg.sv
// ----------------------------------------------------------------------------
// mbfs_pkg
// Shared types and constants of the motor bridge fault supervisor: command,
// status and bridge action codes, register indexes and reset values, and the
// structs that travel between the supervisor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mbfs_pkg;

  // command codes of one input transaction
  typedef enum logic [2:0] {
    CMD_SCAN     = 3'd0,
    CMD_ENABLE   = 3'd1,
    CMD_DISABLE  = 3'd2,
    CMD_FORWARD  = 3'd3,
    CMD_BACKWARD = 3'd4,
    CMD_STOP     = 3'd5
  } cmd_e;

  // drive status codes
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_ENABLED  = 3'd1,
    ST_MOVING   = 3'd2,
    ST_DEV_ERR  = 3'd3,
    ST_OVERCUR  = 3'd4,
    ST_UNDERCUR = 3'd5
  } status_e;

  // bridge action codes
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_ENABLE   = 3'd1,
    ACT_DISABLE  = 3'd2,
    ACT_FORWARD  = 3'd3,
    ACT_BACKWARD = 3'd4,
    ACT_STOP     = 3'd5
  } action_e;

  // configuration register indexes
  localparam logic [1:0] RegOvercurrentLimit = 2'd0;
  localparam logic [1:0] RegLowCurrentTmo    = 2'd1;
  localparam logic [1:0] RegScanInterval     = 2'd2;

  // register reset values
  localparam logic [15:0] OvercurrentLimitRst = 16'd65535;
  localparam logic [15:0] LowCurrentTmoRst    = 16'd1000;
  localparam logic [7:0]  ScanIntervalRst     = 8'd10;

  // current below which a scan counts as low current (mA)
  localparam logic [15:0] LowCurrentMa = 16'd10;

  // accumulator width: timeout plus one interval never wraps
  localparam int unsigned AccW = 17;

  typedef struct packed {
    logic [15:0] overcurrent_limit;
    logic [15:0] low_current_timeout;
    logic [7:0]  scan_interval;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] current_sample;
    logic        device_ok;
  } item_t;

  typedef struct packed {
    status_e     drive_status;
    logic        error_event;
    action_e     bridge_action;
    logic [15:0] last_current;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/mbfs_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbfs_cfg_regs
// Configuration register file: overcurrent limit, low-current timeout and
// scan interval, written through a plain write port, no read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfs_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [15:0]   cfg_data_i,
  output mbfs_pkg::cfg_t     cfg_o
);

  mbfs_pkg::cfg_t cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overcurrent_limit   <= mbfs_pkg::OvercurrentLimitRst;
      cfg_q.low_current_timeout <= mbfs_pkg::LowCurrentTmoRst;
      cfg_q.scan_interval       <= mbfs_pkg::ScanIntervalRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mbfs_pkg::RegOvercurrentLimit: cfg_q.overcurrent_limit   <= cfg_data_i;
        mbfs_pkg::RegLowCurrentTmo:    cfg_q.low_current_timeout <= cfg_data_i;
        mbfs_pkg::RegScanInterval:     cfg_q.scan_interval       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hdl/mbfs_core.sv
// ----------------------------------------------------------------------------
// mbfs_core
// Supervisor state (drive status, low-current accumulator, stored current)
// and the single-pass next-state logic for one command.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfs_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire mbfs_pkg::item_t   item_i,
  input  wire mbfs_pkg::cfg_t    cfg_i,
  output mbfs_pkg::result_t      result_o
);

  mbfs_pkg::status_e             mode_q, mode_d;
  logic [mbfs_pkg::AccW-1:0]     acc_q, acc_d;
  logic [15:0]                   cur_q, cur_d;
  logic                          err;
  mbfs_pkg::action_e             act;
  logic                          low_watch;
  logic                          acc_over;

  // undercurrent check applies while moving or already in undercurrent
  assign low_watch = ((mode_q == mbfs_pkg::ST_MOVING) || (mode_q == mbfs_pkg::ST_UNDERCUR))
                     && (item_i.current_sample < mbfs_pkg::LowCurrentMa);
  assign acc_over  = acc_q > {1'b0, cfg_i.low_current_timeout};

  // command decode and state update
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    cur_d  = cur_q;
    err    = 1'b0;
    act    = mbfs_pkg::ACT_NONE;
    unique case (item_i.command)
      mbfs_pkg::CMD_SCAN: begin
        cur_d = item_i.current_sample;
        if (!item_i.device_ok) begin
          mode_d = mbfs_pkg::ST_DEV_ERR;
          err    = 1'b1;
        end else if (item_i.current_sample > cfg_i.overcurrent_limit) begin
          mode_d = mbfs_pkg::ST_OVERCUR;
          err    = 1'b1;
        end else if (low_watch) begin
          if (acc_over) begin
            mode_d = mbfs_pkg::ST_UNDERCUR;
            err    = 1'b1;
          end else begin
            acc_d = acc_q + mbfs_pkg::AccW'(cfg_i.scan_interval);
          end
        end else begin
          acc_d = '0;
        end
      end
      mbfs_pkg::CMD_ENABLE: begin
        act    = mbfs_pkg::ACT_ENABLE;
        mode_d = mbfs_pkg::ST_ENABLED;
      end
      mbfs_pkg::CMD_DISABLE: begin
        act    = mbfs_pkg::ACT_DISABLE;
        mode_d = mbfs_pkg::ST_IDLE;
      end
      mbfs_pkg::CMD_FORWARD: begin
        if (mode_q != mbfs_pkg::ST_IDLE) begin
          act    = mbfs_pkg::ACT_FORWARD;
          mode_d = mbfs_pkg::ST_MOVING;
        end
      end
      mbfs_pkg::CMD_BACKWARD: begin
        if (mode_q != mbfs_pkg::ST_IDLE) begin
          act    = mbfs_pkg::ACT_BACKWARD;
          mode_d = mbfs_pkg::ST_MOVING;
        end
      end
      mbfs_pkg::CMD_STOP: begin
        if ((mode_q == mbfs_pkg::ST_ENABLED) || (mode_q == mbfs_pkg::ST_MOVING)) begin
          act    = mbfs_pkg::ACT_STOP;
          mode_d = mbfs_pkg::ST_ENABLED;
        end
      end
      default: ;
    endcase
  end

  // state registers, advanced once per processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mbfs_pkg::ST_IDLE;
      acc_q  <= '0;
      cur_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cur_q  <= cur_d;
    end
  end

  // result of this command
  always_comb begin
    result_o.drive_status  = mode_d;
    result_o.error_event   = err;
    result_o.bridge_action = act;
    result_o.last_current  = cur_d;
  end

endmodule

`default_nettype wire

// File: hdl/motor_bridge_fault_supervisor_top.sv
// ----------------------------------------------------------------------------
// motor_bridge_fault_supervisor_top
// H-bridge motor driver fault supervisor: decodes bridge commands and checks
// each current scan for device fault, overcurrent and undercurrent.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  command, current_sample,
//                                                device_ok
//   out      source     out_valid_o / out_stall_i drive_status, error_event,
//                                                bridge_action, last_current
//   cfg      sink       cfg_we_i                 cfg_index_i, cfg_data_i
//
// One command per clock sustained while the result side does not stall; an
// accepted transaction passes through the input register and then the result
// register before it leaves.
// Reset (asynchronous, active low) returns status to idle, clears the
// accumulator and stored current, and loads register defaults.
// A stalled result holds the result register; the input register still
// accepts while the result register is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_bridge_fault_supervisor_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [15:0] current_sample_i,
  input  wire logic        device_ok_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       drive_status_o,
  output logic             error_event_o,
  output logic [2:0]       bridge_action_o,
  output logic [15:0]      last_current_o,
  // configuration port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  mbfs_pkg::cfg_t    cfg;
  mbfs_pkg::item_t   item_q;
  mbfs_pkg::result_t result;
  mbfs_pkg::result_t res_q;
  logic              in_vld_q;
  logic              out_vld_q;
  logic              out_free;
  logic              step;
  logic              in_take;

  // pipeline flow control
  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  mbfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.command        <= command_i;
      item_q.current_sample <= current_sample_i;
      item_q.device_ok      <= device_ok_i;
    end
  end

  mbfs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign drive_status_o  = res_q.drive_status;
  assign error_event_o   = res_q.error_event;
  assign bridge_action_o = res_q.bridge_action;
  assign last_current_o  = res_q.last_current;

  // an error pulse always comes with an error status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.error_event) |->
      (res_q.drive_status == mbfs_pkg::ST_DEV_ERR ||
       res_q.drive_status == mbfs_pkg::ST_OVERCUR ||
       res_q.drive_status == mbfs_pkg::ST_UNDERCUR))
    else $error("error event without error status");

  // a drive action always leaves the bridge moving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.bridge_action == mbfs_pkg::ACT_FORWARD ||
                   res_q.bridge_action == mbfs_pkg::ACT_BACKWARD)) |->
      (res_q.drive_status == mbfs_pkg::ST_MOVING))
    else $error("drive action without moving status");

  // a stop action always leaves the bridge enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.bridge_action == mbfs_pkg::ACT_STOP) |->
      (res_q.drive_status == mbfs_pkg::ST_ENABLED))
    else $error("stop action without enabled status");

  // the input side only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled while result register free");

endmodule

`default_nettype wire

// File: tb/motor_bridge_fault_supervisor_top_tb.sv
// ----------------------------------------------------------------------------
// motor_bridge_fault_supervisor_top_tb
// Self-checking bench for the motor bridge fault supervisor. Command
// transactions are driven from a queue. A behavioural copy of the supervisor
// state (status, low-current accumulator, stored current and limits) predicts
// one report per accepted command. Reports are compared field by field as
// they leave the block. A directed opening is followed by randomised traffic
// under several limit settings. Both sides idle at random, and the result side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_bridge_fault_supervisor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdlePct       = 11;
  localparam int unsigned QuietFrom     = 1000;
  localparam int unsigned QuietTo       = 1300;
  localparam int unsigned HoldAt        = 400;
  localparam int unsigned HoldCycles    = 250;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned PhaseItems    = 320;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned MaxRun        = 280;
  localparam logic [2:0]  CmdSpare6     = 3'd6;
  localparam logic [2:0]  CmdSpare7     = 3'd7;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [2:0]  in_cmd    = mbfs_pkg::CMD_SCAN;
  logic [15:0] in_sample = '0;
  logic        in_ok     = 1'b0;
  logic        out_stall = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = mbfs_pkg::RegOvercurrentLimit;
  logic [15:0] cfg_data  = '0;

  wire logic        in_stall;
  wire logic        out_valid;
  wire logic [2:0]  drive_status;
  wire logic        error_event;
  wire logic [2:0]  bridge_action;
  wire logic [15:0] last_current;

  // shadow of the supervisor state and its limits
  mbfs_pkg::status_e         mode_q       = mbfs_pkg::ST_IDLE;
  logic [mbfs_pkg::AccW-1:0] lowcur_time  = '0;
  logic [15:0]               held_current = '0;
  logic [15:0]               oc_limit     = mbfs_pkg::OvercurrentLimitRst;
  logic [15:0]               lc_timeout   = mbfs_pkg::LowCurrentTmoRst;
  logic [7:0]                scan_step    = mbfs_pkg::ScanIntervalRst;

  mbfs_pkg::item_t   command_q[$];
  mbfs_pkg::result_t report_q[$];
  mbfs_pkg::result_t due_report;
  int unsigned n_accepted   = 0;
  int unsigned n_fail       = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  logic        quiet;

  assign quiet = (n_accepted >= QuietFrom) && (n_accepted < QuietTo);

  motor_bridge_fault_supervisor_top i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (in_cmd),
    .current_sample_i (in_sample),
    .device_ok_i      (in_ok),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .drive_status_o   (drive_status),
    .error_event_o    (error_event),
    .bridge_action_o  (bridge_action),
    .last_current_o   (last_current),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // advance the shadow state by one command and queue the report it gives
  task automatic supervise(input mbfs_pkg::item_t it);
    mbfs_pkg::result_t r;
    r.error_event   = 1'b0;
    r.bridge_action = mbfs_pkg::ACT_NONE;
    case (it.command)
      mbfs_pkg::CMD_SCAN: begin
        held_current = it.current_sample;
        if (!it.device_ok) begin
          mode_q        = mbfs_pkg::ST_DEV_ERR;
          r.error_event = 1'b1;
        end else if (it.current_sample > oc_limit) begin
          mode_q        = mbfs_pkg::ST_OVERCUR;
          r.error_event = 1'b1;
        end else if ((mode_q == mbfs_pkg::ST_MOVING || mode_q == mbfs_pkg::ST_UNDERCUR) &&
                     it.current_sample < mbfs_pkg::LowCurrentMa) begin
          if (lowcur_time > lc_timeout) begin
            mode_q        = mbfs_pkg::ST_UNDERCUR;
            r.error_event = 1'b1;
          end else begin
            lowcur_time = lowcur_time + scan_step;
          end
        end else begin
          lowcur_time = '0;
        end
      end
      mbfs_pkg::CMD_ENABLE: begin
        r.bridge_action = mbfs_pkg::ACT_ENABLE;
        mode_q          = mbfs_pkg::ST_ENABLED;
      end
      mbfs_pkg::CMD_DISABLE: begin
        r.bridge_action = mbfs_pkg::ACT_DISABLE;
        mode_q          = mbfs_pkg::ST_IDLE;
      end
      mbfs_pkg::CMD_FORWARD, mbfs_pkg::CMD_BACKWARD: begin
        if (mode_q != mbfs_pkg::ST_IDLE) begin
          r.bridge_action = (it.command == mbfs_pkg::CMD_FORWARD) ?
                            mbfs_pkg::ACT_FORWARD : mbfs_pkg::ACT_BACKWARD;
          mode_q          = mbfs_pkg::ST_MOVING;
        end
      end
      mbfs_pkg::CMD_STOP: begin
        if (mode_q == mbfs_pkg::ST_ENABLED || mode_q == mbfs_pkg::ST_MOVING) begin
          r.bridge_action = mbfs_pkg::ACT_STOP;
          mode_q          = mbfs_pkg::ST_ENABLED;
        end
      end
      default: begin
      end
    endcase
    r.drive_status = mode_q;
    r.last_current = held_current;
    report_q.push_back(r);
  endtask

  task automatic add_item(input logic [2:0] cmd, input logic [15:0] sample, input logic ok);
    command_q.push_back(mbfs_pkg::item_t'{cmd, sample, ok});
  endtask

  // current sample biased towards the thresholds of the present setting
  function automatic logic [15:0] pick_current();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return mbfs_pkg::LowCurrentMa - 16'd1;
      2:       return mbfs_pkg::LowCurrentMa;
      3:       return oc_limit;
      4:       return oc_limit + 16'd1;
      5:       return 16'hFFFF;
      6, 7:    return 16'($urandom_range(9));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // wait until the block has nothing left to do
  task automatic drain();
    @(negedge clk);
    while (command_q.size() != 0 || in_valid || report_q.size() != 0) @(negedge clk);
  endtask

  // write all three limit registers back to back
  task automatic program_limits(input logic [15:0] lim, input logic [15:0] tmo,
                                input logic [7:0] step);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= mbfs_pkg::RegOvercurrentLimit;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_index <= mbfs_pkg::RegLowCurrentTmo;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_index <= mbfs_pkg::RegScanInterval;
    cfg_data  <= {8'd0, step};
    @(posedge clk);
    cfg_we     <= 1'b0;
    oc_limit   = lim;
    lc_timeout = tmo;
    scan_step  = step;
  endtask

  // mostly motion runs of low-current scans, with loose commands and noise
  task automatic random_traffic(input int unsigned n);
    int unsigned made;
    int unsigned run;
    int unsigned step;
    made = 0;
    while (made < n) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          step = (scan_step == 0) ? 1 : scan_step;
          run  = lc_timeout / step + 4;
          if (run > MaxRun) run = MaxRun;
          if ($urandom_range(1)) run = $urandom_range(1, run);
          if (run + 3 > n - made) run = (n - made > 3) ? n - made - 3 : 1;
          add_item(mbfs_pkg::CMD_ENABLE, 16'($urandom), 1'($urandom));
          add_item($urandom_range(1) ? mbfs_pkg::CMD_FORWARD : mbfs_pkg::CMD_BACKWARD,
                   16'($urandom), 1'($urandom));
          for (int unsigned k = 0; k < run; k++) begin
            add_item(mbfs_pkg::CMD_SCAN,
                     ($urandom_range(19) != 0) ? 16'($urandom_range(9)) : pick_current(),
                     $urandom_range(39) != 0);
          end
          case ($urandom_range(2))
            0: begin
              add_item(mbfs_pkg::CMD_STOP, 16'($urandom), 1'($urandom));
              made++;
            end
            1: begin
              add_item(mbfs_pkg::CMD_DISABLE, 16'($urandom), 1'($urandom));
              made++;
            end
            default: begin
            end
          endcase
          made += run + 2;
        end
        12, 13, 14, 15, 16, 17: begin
          add_item(3'($urandom_range(5)), pick_current(), $urandom_range(9) != 0);
          made++;
        end
        default: begin
          add_item($urandom_range(1) ? CmdSpare6 : CmdSpare7, 16'($urandom), 1'($urandom));
          made++;
        end
      endcase
    end
  endtask

  // command driver: holds a stalled transaction, otherwise loads or idles
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        supervise(mbfs_pkg::item_t'{in_cmd, in_sample, in_ok});
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (command_q.size() != 0 && (quiet || $urandom_range(99) >= IdlePct)) begin
          {in_cmd, in_sample, in_ok} <= command_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side stall: random, plus one long hold-off to back the block up
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!hold_done && n_accepted >= HoldAt) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IdlePct);
    end
  end

  // report checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("%0t: unexpected report: status %0d err %0b action %0d current %0d",
                   $realtime, drive_status, error_event, bridge_action, last_current);
      end else begin
        due_report = report_q.pop_front();
        if (drive_status !== due_report.drive_status ||
            error_event !== due_report.error_event ||
            bridge_action !== due_report.bridge_action ||
            last_current !== due_report.last_current) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: mismatch: status %0d/%0d err %0b/%0b act %0d/%0d cur %0d/%0d",
                     $realtime, due_report.drive_status, drive_status,
                     due_report.error_event, error_event, due_report.bridge_action,
                     bridge_action, due_report.last_current, last_current);
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WatchdogLimit) begin
      $display("motor_bridge_fault_supervisor_top_tb NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset limits: commands from idle, fault, stop rules, ignored codes
    add_item(mbfs_pkg::CMD_FORWARD, 16'hFFFF, 1'b1);
    add_item(mbfs_pkg::CMD_STOP, 16'h0000, 1'b0);
    add_item(mbfs_pkg::CMD_SCAN, 16'hFFFF, 1'b1);
    add_item(mbfs_pkg::CMD_SCAN, 16'h0000, 1'b0);
    add_item(mbfs_pkg::CMD_STOP, 16'h5A5A, 1'b1);
    add_item(mbfs_pkg::CMD_BACKWARD, 16'hA5A5, 1'b0);
    add_item(mbfs_pkg::CMD_SCAN, 16'd5, 1'b1);
    add_item(CmdSpare6, 16'hFFFF, 1'b1);
    add_item(CmdSpare7, 16'h1234, 1'b0);
    add_item(mbfs_pkg::CMD_ENABLE, 16'h0000, 1'b1);
    add_item(mbfs_pkg::CMD_FORWARD, 16'h0000, 1'b1);
    add_item(mbfs_pkg::CMD_STOP, 16'h0000, 1'b1);
    add_item(mbfs_pkg::CMD_DISABLE, 16'h0000, 1'b1);
    add_item(mbfs_pkg::CMD_ENABLE, 16'h0000, 1'b1);
    drain();

    // zero timeout and zero interval: the low-current time left from the opening trips undercurrent
    program_limits(16'd100, 16'd0, 8'd0);
    @(negedge clk);
    add_item(mbfs_pkg::CMD_FORWARD, 16'd0, 1'b1);
    add_item(mbfs_pkg::CMD_SCAN, 16'd0, 1'b1);
    add_item(mbfs_pkg::CMD_SCAN, mbfs_pkg::LowCurrentMa - 16'd1, 1'b1);
    add_item(mbfs_pkg::CMD_SCAN, 16'd101, 1'b1);
    add_item(mbfs_pkg::CMD_SCAN, 16'd100, 1'b1);
    drain();

    // unit interval: undercurrent on the second low scan and after
    program_limits(16'd100, 16'd0, 8'd1);
    @(negedge clk);
    add_item(mbfs_pkg::CMD_ENABLE, 16'd0, 1'b1);
    add_item(mbfs_pkg::CMD_FORWARD, 16'd0, 1'b1);
    add_item(mbfs_pkg::CMD_SCAN, 16'd3, 1'b1);
    add_item(mbfs_pkg::CMD_SCAN, 16'd3, 1'b1);
    add_item(mbfs_pkg::CMD_SCAN, 16'd3, 1'b1);
    add_item(mbfs_pkg::CMD_SCAN, 16'd50, 1'b1);
    add_item(mbfs_pkg::CMD_STOP, 16'd0, 1'b1);
    add_item(mbfs_pkg::CMD_FORWARD, 16'd0, 1'b1);
    add_item(mbfs_pkg::CMD_DISABLE, 16'd0, 1'b1);
    drain();

    // random traffic under a range of limit settings
    for (int unsigned phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       program_limits(16'd1200, 16'd60, 8'd7);
        1:       program_limits(16'hFFFF, 16'hFFFF, 8'hFF);
        2:       program_limits(16'd0, 16'd0, 8'd1);
        3:       program_limits(16'($urandom_range(65535)), 16'($urandom_range(2000)),
                                8'($urandom_range(1, 255)));
        4:       program_limits(16'd3000, 16'd300, 8'd25);
        default: program_limits(mbfs_pkg::OvercurrentLimitRst, mbfs_pkg::LowCurrentTmoRst,
                                mbfs_pkg::ScanIntervalRst);
      endcase
      @(negedge clk);
      random_traffic(PhaseItems);
      drain();
    end

    repeat (SettleCycles) @(negedge clk);
    if (n_fail == 0 && report_q.size() == 0)
      $display("motor_bridge_fault_supervisor_top_tb OK");
    else
      $display("motor_bridge_fault_supervisor_top_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// File: motor_bridge_fault_supervisor_top.f
hdl/mbfs_pkg.sv
hdl/mbfs_cfg_regs.sv
hdl/mbfs_core.sv
hdl/motor_bridge_fault_supervisor_top.sv
tb/motor_bridge_fault_supervisor_top_tb.sv
